// File: rtl/cote_pkg.sv
// Shared types and constants for the cursor opaque extent trimmer.
package cote_pkg;

   localparam int MAX_DIM  = 256;
   localparam int MIN_SIZE = 16;

   localparam int COL_W    = $clog2(MAX_DIM);
   localparam int DIM_W    = COL_W + 1;
   localparam int HEIGHT_W = DIM_W + 1;
   localparam int ARGB_W   = 32;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   localparam int ALIGN_STEP = 16;

   localparam logic [COL_W-1:0]  START_EXTENT = COL_W'(MIN_SIZE - 1);
   localparam logic [DIM_W-1:0]  ALIGN_ADD    = DIM_W'(ALIGN_STEP);
   localparam logic [DIM_W-1:0]  ALIGN_MASK   = ~DIM_W'(ALIGN_STEP - 1);

   localparam logic [ARGB_W-1:0] ALPHA_MASK = 32'hFF00_0000;
   localparam logic [ARGB_W-1:0] RGB_MASK   = 32'h00FF_FFFF;

   typedef enum logic [1:0] {
      CURSOR_MONO   = 2'd0,
      CURSOR_COLOR  = 2'd1,
      CURSOR_MASKED = 2'd2
   } cursor_kind_type;

   typedef enum logic [1:0] {
      CSR_CURSOR_TYPE  = 2'd0,
      CSR_SHAPE_WIDTH  = 2'd1,
      CSR_SHAPE_HEIGHT = 2'd2
   } csr_index_type;

   localparam logic [1:0]       RESET_CURSOR_TYPE = CURSOR_COLOR;
   localparam logic [DIM_W-1:0] RESET_SHAPE_DIM   = DIM_W'(32);

   typedef struct packed {
      logic [1:0]       cursor_type;
      logic [DIM_W-1:0] shape_width;
      logic [DIM_W-1:0] shape_height;
   } cfg_type;

endpackage

// File: rtl/cote_if.sv
// Request and result channel interfaces.
interface cote_req_if import cote_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [COL_W-1:0]  pixel_col;
   logic [COL_W-1:0]  pixel_row;
   logic              and_bit;
   logic              xor_bit;
   logic [ARGB_W-1:0] argb_word;
   logic              last_pixel;

   modport source (output valid, pixel_col, pixel_row, and_bit, xor_bit, argb_word,
                   last_pixel, input ready);
   modport sink (input valid, pixel_col, pixel_row, and_bit, xor_bit, argb_word,
                 last_pixel, output ready);
endinterface

interface cote_rsp_if import cote_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [DIM_W-1:0]    new_width;
   logic [HEIGHT_W-1:0] new_height;
   logic                height_changed;

   modport source (output valid, new_width, new_height, height_changed, input ready);
   modport sink (input valid, new_width, new_height, height_changed, output ready);
endinterface

// File: rtl/cote_csr.sv
// Configuration registers behind the APB-style port.
module cote_csr import cote_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic [1:0] index;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign index      = csr_paddr[CSR_AW-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            CSR_CURSOR_TYPE:  cfg_in.cursor_type  = csr_pwdata[1:0];
            CSR_SHAPE_WIDTH:  cfg_in.shape_width  = csr_pwdata[DIM_W-1:0];
            CSR_SHAPE_HEIGHT: cfg_in.shape_height = csr_pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         CSR_CURSOR_TYPE:  csr_prdata = CSR_DW'(cfg_ff.cursor_type);
         CSR_SHAPE_WIDTH:  csr_prdata = CSR_DW'(cfg_ff.shape_width);
         CSR_SHAPE_HEIGHT: csr_prdata = CSR_DW'(cfg_ff.shape_height);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cursor_type  <= RESET_CURSOR_TYPE;
         cfg_ff.shape_width  <= RESET_SHAPE_DIM;
         cfg_ff.shape_height <= RESET_SHAPE_DIM;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/cote_classify.sv
// Opaque/transparent decision for one pixel, including the shape bounds check.
module cote_classify import cote_pkg::*; (
   input  cfg_type           cfg,
   input  logic [COL_W-1:0]  pixel_col,
   input  logic [COL_W-1:0]  pixel_row,
   input  logic              and_bit,
   input  logic              xor_bit,
   input  logic [ARGB_W-1:0] argb_word,
   output logic              opaque
);

   logic       in_shape;
   logic       transparent;
   logic [7:0] alpha;

   assign alpha    = argb_word[31:24];
   // columns and rows are below MAX_DIM by their width
   assign in_shape = ({1'b0, pixel_col} < cfg.shape_width) &&
                     ({1'b0, pixel_row} < cfg.shape_height);

   always_comb begin
      case (cfg.cursor_type)
         CURSOR_MONO:  transparent = and_bit && !xor_bit;
         CURSOR_COLOR: transparent = !alpha[7];
         // masked color; the unused code behaves the same
         default:      transparent = ((argb_word & ALPHA_MASK) != '0) &&
                                     ((argb_word & RGB_MASK) == '0);
      endcase
   end

   assign opaque = in_shape && !transparent;

endmodule

// File: rtl/cursor_opaque_extent_trimmer_unit.sv
// Top level of the cursor opaque extent trimmer.
//
// Usage: the pixels of one cursor shape stream in on the req channel, one
// request per pixel (column, row, AND/XOR mask bits, ARGB word, last flag).
// Opaque pixels inside the shape raise a running max of column and row,
// both starting at MIN_SIZE-1. The request flagged last yields exactly one
// result on the rsp channel: width rounded up to 16 (capped at shape_width),
// height as last opaque row + 1 (capped at shape_height, doubled for
// monochrome) and a height-changed flag. Other requests yield nothing.
// Channels: valid/ready; a request moves when both are high.
// Throughput: one request per cycle while no last pixel waits on a full result register.
// Pipeline: two register stages (input register, then result register); a
//   last pixel's result is written into the result register once that
//   register is free, and is held there until the rsp channel takes it.
// Stall: a waiting result does not block non-last pixels; a second last pixel
//   waits in the input register until the result register is free.
// Reset: clears both stages, sets the running maxima to MIN_SIZE-1 and
//   loads cursor_type=1, shape_width=shape_height=32. Configure only while the block is idle.
module cursor_opaque_extent_trimmer_unit import cote_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   cote_req_if.sink          req,
   cote_rsp_if.source        rsp,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type cfg;

   // input register
   logic              s1_valid_ff, s1_valid_in;
   logic [COL_W-1:0]  s1_col_ff, s1_row_ff;
   logic              s1_and_ff, s1_xor_ff, s1_last_ff;
   logic [ARGB_W-1:0] s1_argb_ff;

   // running extent
   logic [COL_W-1:0]  max_col_ff, max_col_in;
   logic [COL_W-1:0]  max_row_ff, max_row_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DIM_W-1:0]    rsp_width_ff;
   logic [HEIGHT_W-1:0] rsp_height_ff;
   logic                rsp_changed_ff;

   logic                take_req, advance, out_free, opaque;
   logic [COL_W-1:0]    fin_col, fin_row;
   logic [DIM_W-1:0]    rounded, width, trimmed_h, height_half;
   logic [HEIGHT_W-1:0] height;

   cote_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cote_classify u_classify (
      .cfg       (cfg),
      .pixel_col (s1_col_ff),
      .pixel_row (s1_row_ff),
      .and_bit   (s1_and_ff),
      .xor_bit   (s1_xor_ff),
      .argb_word (s1_argb_ff),
      .opaque    (opaque)
   );

   // Only a last pixel needs room in the result register.
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign advance   = s1_valid_ff && (!s1_last_ff || out_free);
   assign req.ready = !s1_valid_ff || advance;
   assign take_req  = req.valid && req.ready;

   // Extent including the pixel in the input register.
   assign fin_col = (opaque && (s1_col_ff > max_col_ff)) ? s1_col_ff : max_col_ff;
   assign fin_row = (opaque && (s1_row_ff > max_row_ff)) ? s1_row_ff : max_row_ff;

   // Width: (col + 1) rounded up to a multiple of 16, kept only if smaller.
   assign rounded = ({1'b0, fin_col} + ALIGN_ADD) & ALIGN_MASK;
   assign width   = (rounded < cfg.shape_width) ? rounded : cfg.shape_width;

   // Height: last opaque row + 1, capped at the original, doubled for mono.
   assign trimmed_h   = {1'b0, fin_row} + DIM_W'(1);
   assign height_half = (trimmed_h < cfg.shape_height) ? trimmed_h : cfg.shape_height;
   assign height      = (cfg.cursor_type == CURSOR_MONO) ? {height_half, 1'b0}
                                                         : {1'b0, height_half};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (take_req) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      max_col_in = max_col_ff;
      max_row_in = max_row_ff;
      if (advance) begin
         max_col_in = s1_last_ff ? START_EXTENT : fin_col;
         max_row_in = s1_last_ff ? START_EXTENT : fin_row;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_col_ff   <= START_EXTENT;
         max_row_ff   <= START_EXTENT;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         max_col_ff   <= max_col_in;
         max_row_ff   <= max_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         s1_col_ff  <= req.pixel_col;
         s1_row_ff  <= req.pixel_row;
         s1_and_ff  <= req.and_bit;
         s1_xor_ff  <= req.xor_bit;
         s1_argb_ff <= req.argb_word;
         s1_last_ff <= req.last_pixel;
      end
      if (advance && s1_last_ff) begin
         rsp_width_ff   <= width;
         rsp_height_ff  <= height;
         rsp_changed_ff <= (trimmed_h != cfg.shape_height);
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.new_width      = rsp_width_ff;
   assign rsp.new_height     = rsp_height_ff;
   assign rsp.height_changed = rsp_changed_ff;

endmodule

// File: rtl/cote_checker.sv
// Port-level checker for the trimmer, bound to the top level.
module cote_checker import cote_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                req_last,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [DIM_W-1:0]    rsp_width,
   input logic [HEIGHT_W-1:0] rsp_height,
   input logic                rsp_changed,
   input logic                csr_pready
);

   // last pixels taken whose result has not yet been delivered
   logic [2:0] pend_ff, pend_in;
   logic       last_in, rsp_out;

   assign last_in = req_valid && req_ready && req_last;
   assign rsp_out = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff + 3'(last_in) - 3'(rsp_out);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_no_invented_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 3'd0)
      else $error("result shown without a pending last pixel");

   a_pending_bounded: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 3'd2)
      else $error("more than two results in flight");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_width) &&
                                  $stable(rsp_height) && $stable(rsp_changed))
      else $error("stalled result changed");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("csr port not ready");

endmodule

bind cursor_opaque_extent_trimmer_unit cote_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .req_last    (req.last_pixel),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_width   (rsp.new_width),
   .rsp_height  (rsp.new_height),
   .rsp_changed (rsp.height_changed),
   .csr_pready  (csr_pready)
);

// File: verif/cursor_opaque_extent_trimmer_unit_tb.sv
// Self-checking testbench for the cursor opaque extent trimmer: pixel streams in, trimmed extents out.
module cursor_opaque_extent_trimmer_unit_tb import cote_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   // Run bounds. The cycle limit lies far above the slowest correct run.
   localparam int CYCLE_LIMIT    = 200000;
   localparam int RANDOM_PIXELS  = 400;
   localparam int LONG_HOLD      = 120;
   localparam int PRESSURE_SHAPES = 30;
   localparam int SETTLE_CYCLES  = 4;

   // Type code 3 has no enum member; the block treats it like masked color.
   localparam logic [1:0] CURSOR_UNUSED = 2'd3;

   // One pixel request and one trimmed-extent result, at the block's widths.
   typedef struct packed {
      logic [COL_W-1:0]  col;
      logic [COL_W-1:0]  row;
      logic              and_bit;
      logic              xor_bit;
      logic [ARGB_W-1:0] argb;
      logic              last;
   } pixel_type;

   typedef struct packed {
      logic [DIM_W-1:0]    width;
      logic [HEIGHT_W-1:0] height;
      logic                changed;
   } extent_type;

   // ---------------------------------------------------------------------
   // Extent predictor and store of expected extents.
   // Tracks the running opaque maxima per shape, exactly as the block should,
   // and queues one expected extent per last pixel.
   // ---------------------------------------------------------------------
   class extent_scoreboard;
      cfg_type          cfg;
      logic [COL_W-1:0] max_col;
      logic [COL_W-1:0] max_row;
      extent_type       expected_extents[$];
      int               failures;
      int               pixels_seen;
      int               extents_checked;

      function new();
         cfg.cursor_type  = RESET_CURSOR_TYPE;
         cfg.shape_width  = RESET_SHAPE_DIM;
         cfg.shape_height = RESET_SHAPE_DIM;
         max_col          = START_EXTENT;
         max_row          = START_EXTENT;
         failures         = 0;
         pixels_seen      = 0;
         extents_checked  = 0;
      endfunction

      function void flag(string msg);
         failures++;
         if (failures <= 10) $display("ERROR: %s", msg);
      endfunction

      function void set_reg(csr_index_type idx, logic [CSR_DW-1:0] value);
         case (idx)
            CSR_CURSOR_TYPE:  cfg.cursor_type  = value[1:0];
            CSR_SHAPE_WIDTH:  cfg.shape_width  = value[DIM_W-1:0];
            CSR_SHAPE_HEIGHT: cfg.shape_height = value[DIM_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_pixel(pixel_type p);
         logic [7:0]  alpha;
         bit          clear;
         bit          in_shape;
         int unsigned rounded;
         int unsigned width;
         int unsigned trimmed;
         int unsigned height;
         extent_type  e;
         pixels_seen++;
         alpha = 8'((p.argb & ALPHA_MASK) >> 24);
         case (cfg.cursor_type)
            CURSOR_MONO:  clear = p.and_bit && !p.xor_bit;
            CURSOR_COLOR: clear = alpha < 8'd128;
            default:      clear = alpha != 8'd0 && (p.argb & RGB_MASK) == '0;
         endcase
         in_shape = p.col < cfg.shape_width && p.row < cfg.shape_height;
         if (in_shape && !clear) begin
            if (p.col > max_col) max_col = p.col;
            if (p.row > max_row) max_row = p.row;
         end
         if (!p.last) return;
         // (max+1) rounded up to the alignment step
         rounded = (32'(max_col) + 32'(ALIGN_STEP)) & ~32'(ALIGN_STEP - 1);
         width   = (rounded < cfg.shape_width) ? rounded : 32'(cfg.shape_width);
         trimmed = 32'(max_row) + 1;
         height  = (trimmed < cfg.shape_height) ? trimmed : 32'(cfg.shape_height);
         if (cfg.cursor_type == CURSOR_MONO) height = height * 2;
         e.width   = DIM_W'(width);
         e.height  = HEIGHT_W'(height);
         e.changed = trimmed != 32'(cfg.shape_height);
         expected_extents.push_back(e);
         max_col = START_EXTENT;
         max_row = START_EXTENT;
      endfunction

      function void check_result(extent_type got);
         extent_type want;
         extents_checked++;
         if (expected_extents.size() == 0) begin
            flag($sformatf("result w=%0d h=%0d chg=%0d with no last pixel pending",
                           got.width, got.height, got.changed));
            return;
         end
         want = expected_extents.pop_front();
         if (got.width !== want.width)
            flag($sformatf("new_width: expected %0d, got %0d", want.width, got.width));
         if (got.height !== want.height)
            flag($sformatf("new_height: expected %0d, got %0d", want.height, got.height));
         if (got.changed !== want.changed)
            flag($sformatf("height_changed: expected %0d, got %0d",
                           want.changed, got.changed));
      endfunction

      function int pending();
         return expected_extents.size();
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // Clock, reset, channels, APB-style register port
   // ---------------------------------------------------------------------
   logic clock;
   logic reset;

   cote_req_if req_if ();
   cote_rsp_if rsp_if ();

   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   cursor_opaque_extent_trimmer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   extent_scoreboard sb = new();

   // Idle modes per phase; hold_request asks the result side for one long stall.
   bit req_idle;
   bit rsp_idle;
   int hold_request;
   int cycle_count;
   int stall_cycles;
   int settings_used;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: any hang ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Monitor. Right after the edge, reads still see the values the edge sampled,
   // so a handshake here is exactly the one the block took.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            sb.note_pixel('{req_if.pixel_col, req_if.pixel_row, req_if.and_bit,
                            req_if.xor_bit, req_if.argb_word, req_if.last_pixel});
         end
         if (req_if.valid && !req_if.ready) stall_cycles++;
         if (rsp_if.valid && rsp_if.ready) begin
            sb.check_result('{rsp_if.new_width, rsp_if.new_height, rsp_if.height_changed});
         end
      end
   end

   // Result side: draws a random wait per result (or none when rsp_idle is
   // clear), and once takes the long hold that the main flow asks for.
   initial begin
      int wait_cycles;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request > 0) begin
            wait_cycles  = hold_request;
            hold_request = 0;
         end else begin
            wait_cycles = rsp_idle ? $urandom_range(0, 5) : 0;
         end
         if (wait_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // ---------------------------------------------------------------------
   // Drivers. Every task starts and ends on a rising edge.
   // ---------------------------------------------------------------------

   // One register access: setup phase, access phase, then idle with psel low so the
   // next access never drives psel twice in the same step.
   task automatic csr_access(bit is_write, csr_index_type idx, logic [CSR_DW-1:0] wdata,
                             output logic [CSR_DW-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= CSR_AW'(idx) << 2;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Write a register, mirror it in the predictor, and read it back.
   task automatic write_csr(csr_index_type idx, logic [CSR_DW-1:0] value);
      logic [CSR_DW-1:0] readback;
      csr_access(1'b1, idx, value, readback);
      sb.set_reg(idx, value);
      csr_access(1'b0, idx, '0, readback);
      if (readback !== value)
         sb.flag($sformatf("register %s readback: expected %0d, got %0d",
                           idx.name(), value, readback));
   endtask

   task automatic configure(logic [1:0] kind, logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
      write_csr(CSR_CURSOR_TYPE, CSR_DW'(kind));
      write_csr(CSR_SHAPE_WIDTH, CSR_DW'(w));
      write_csr(CSR_SHAPE_HEIGHT, CSR_DW'(h));
      settings_used++;
   endtask

   // Offer one pixel request; returns on the edge that accepted it. valid stays
   // high into the next request unless a gap is drawn.
   task automatic send_pixel(pixel_type p);
      int gap;
      gap = req_idle ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.pixel_col  <= p.col;
      req_if.pixel_row  <= p.row;
      req_if.and_bit    <= p.and_bit;
      req_if.xor_bit    <= p.xor_bit;
      req_if.argb_word  <= p.argb;
      req_if.last_pixel <= p.last;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Drop valid, let the monitor log the final request, wait for every
   // outstanding extent, then let the pipeline empty (two stages, plus margin)
   // before any register write.
   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic pixel_type px(int c, int r, bit a, bit x, logic [ARGB_W-1:0] argb,
                                    bit last);
      return '{COL_W'(c), COL_W'(r), a, x, argb, last};
   endfunction

   // Mostly pixels inside the current shape; some anywhere in the 8-bit range.
   // Alpha favors the threshold values so every classification is exercised.
   function automatic pixel_type random_pixel(bit last);
      pixel_type   p;
      int unsigned wlim;
      int unsigned hlim;
      wlim = (sb.cfg.shape_width > MAX_DIM) ? MAX_DIM : sb.cfg.shape_width;
      hlim = (sb.cfg.shape_height > MAX_DIM) ? MAX_DIM : sb.cfg.shape_height;
      if (wlim == 0 || $urandom_range(0, 4) == 0) p.col = COL_W'($urandom);
      else p.col = COL_W'($urandom_range(0, wlim - 1));
      if (hlim == 0 || $urandom_range(0, 4) == 0) p.row = COL_W'($urandom);
      else p.row = COL_W'($urandom_range(0, hlim - 1));
      p.and_bit = 1'($urandom);
      p.xor_bit = 1'($urandom);
      case ($urandom_range(0, 5))
         0:       p.argb[31:24] = 8'd0;
         1:       p.argb[31:24] = 8'd127;
         2:       p.argb[31:24] = 8'd128;
         3:       p.argb[31:24] = 8'd255;
         4:       p.argb[31:24] = 8'd1;
         default: p.argb[31:24] = 8'($urandom);
      endcase
      p.argb[23:0] = ($urandom_range(0, 2) == 0) ? 24'd0 : 24'($urandom);
      p.last = last;
      return p;
   endfunction

   function automatic logic [DIM_W-1:0] pick_dim();
      case ($urandom_range(0, 9))
         0:       return DIM_W'(1);
         1:       return DIM_W'(MIN_SIZE);
         2:       return DIM_W'(MAX_DIM);
         3:       return DIM_W'(MIN_SIZE + 1);
         // out-of-range register values: zero and all ones
         4:       return ($urandom_range(0, 1) != 0) ? DIM_W'(0) : '1;
         default: return DIM_W'($urandom_range(1, MAX_DIM));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int random_sent;
      int shapes;
      int len;
      bit pressure_done;

      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.pixel_col  <= '0;
      req_if.pixel_row  <= '0;
      req_if.and_bit    <= 1'b0;
      req_if.xor_bit    <= 1'b0;
      req_if.argb_word  <= '0;
      req_if.last_pixel <= 1'b0;
      csr_psel          <= 1'b0;
      csr_penable       <= 1'b0;
      csr_pwrite        <= 1'b0;
      csr_paddr         <= '0;
      csr_pwdata        <= '0;
      cycle_count       = 0;
      stall_cycles      = 0;
      settings_used     = 1;
      hold_request      = 0;
      req_idle          = 1'b1;
      rsp_idle          = 1'b1;
      random_sent       = 0;
      pressure_done     = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- Directed part ---
      // Reset settings (color, 32x32): nothing opaque keeps the 16x16 floor,
      // alpha 128 is opaque at the far corner, alpha 127 is clear and a pixel
      // outside the shape is ignored while its last flag still closes the shape.
      send_pixel(px(0, 0, 0, 0, 32'h7F00_0000, 1'b1));
      send_pixel(px(31, 31, 0, 0, 32'h8000_0000, 1'b1));
      send_pixel(px(20, 3, 0, 0, 32'h7FFF_FFFF, 1'b0));
      send_pixel(px(255, 255, 0, 0, 32'hFFFF_FFFF, 1'b1));
      settle();

      // Monochrome at full size: all four AND/XOR combinations, extreme columns
      // and rows; height comes back doubled.
      configure(CURSOR_MONO, DIM_W'(MAX_DIM), DIM_W'(MAX_DIM));
      send_pixel(px(255, 255, 1, 0, 32'h0, 1'b0));
      send_pixel(px(255, 0, 0, 0, 32'h0, 1'b0));
      send_pixel(px(0, 200, 1, 1, 32'h0, 1'b0));
      send_pixel(px(100, 255, 0, 1, 32'hFFFF_FFFF, 1'b1));
      settle();

      // Masked color: alpha with zero RGB is clear, all-zero word is opaque,
      // column on the width edge is outside. Width rounds to 64 below 100.
      configure(CURSOR_MASKED, DIM_W'(100), DIM_W'(40));
      send_pixel(px(99, 39, 0, 0, 32'h0100_0000, 1'b0));
      send_pixel(px(100, 5, 0, 0, 32'h0, 1'b0));
      send_pixel(px(50, 10, 0, 0, 32'h0, 1'b0));
      send_pixel(px(60, 39, 1, 0, 32'hFF00_0001, 1'b1));
      settle();

      // Unused type code behaves as masked color; shape smaller than the floor.
      configure(CURSOR_UNUSED, DIM_W'(8), DIM_W'(5));
      send_pixel(px(7, 4, 0, 0, 32'h0, 1'b1));
      settle();

      // Zero-sized shape: every pixel outside, extent collapses to zero.
      configure(CURSOR_MONO, DIM_W'(0), DIM_W'(0));
      send_pixel(px(0, 0, 0, 0, 32'h0, 1'b1));
      settle();

      // All-ones register values: capped by the 8-bit coordinates instead.
      configure(CURSOR_MONO, '1, '1);
      send_pixel(px(255, 255, 0, 0, 32'h0, 1'b1));
      settle();

      // --- Random part ---
      // Each phase: fresh settings and idle modes, then a few short shapes each
      // closed by a last pixel. One phase is a burst of single-pixel shapes with
      // the result side held off, so the result stage fills and the input stalls.
      while (random_sent < RANDOM_PIXELS) begin
         configure(2'($urandom_range(0, 3)), pick_dim(), pick_dim());
         req_idle = $urandom_range(0, 2) != 0;
         rsp_idle = $urandom_range(0, 2) != 0;
         if (!pressure_done && random_sent >= RANDOM_PIXELS / 3) begin
            pressure_done = 1'b1;
            req_idle      = 1'b0;
            hold_request  = LONG_HOLD;
            repeat (PRESSURE_SHAPES) begin
               send_pixel(random_pixel(1'b1));
               random_sent++;
            end
         end else begin
            shapes = $urandom_range(1, 6);
            repeat (shapes) begin
               len = $urandom_range(1, 16);
               for (int i = 0; i < len; i++) begin
                  send_pixel(random_pixel(i == len - 1));
                  random_sent++;
               end
            end
         end
         settle();
      end

      // --- Wrap-up ---
      if (sb.pending() != 0)
         sb.flag($sformatf("%0d expected extents never arrived", sb.pending()));
      $display("tb: %0d pixel requests, %0d extents checked over %0d register settings",
               sb.pixels_seen, sb.extents_checked, settings_used);
      $display("tb: input stalled %0d cycles under result back-pressure, %0d mismatches",
               stall_cycles, sb.failures);
      if (sb.failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
